// ===== design/mfds_pkg.sv =====
package mfds_pkg;

  localparam int NUM_CORES   = 4;
  localparam int READY_DEPTH = 64;
  localparam int SLEEP_SLOTS = 64;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_REQ  = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_DISP = 2'd1;
  localparam logic [1:0] KIND_NEW  = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;

  localparam logic [15:0] QUANTUM_RST = 16'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  task_id;
    logic [15:0] sleep_ticks;
    logic [3:0]  core_free;
    logic        batch_on;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  core_index;
    logic [7:0]  out_task;
    logic [15:0] budget;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       simple;
    logic       scan_start;
    logic       scan_step;
    logic       gen;
    logic       pop_rd;
    logic       disp;
    logic       ack;
    logic [1:0] core;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       sleep_empty;
    logic       last_slot;
    logic       ready_empty;
    logic       gen_now;
    logic       can_disp;
    logic [3:0] core_free;
    logic       out_free;
  } sts_t;

endpackage

// ===== design/multicore_fifo_dispatch_with_sleep.sv =====
// one request at a time; add and requeue pass the accept state and S_SIMPLE, plus output wait
// a tick passes the accept state, S_SIMPLE, S_SCAN0, one S_SCAN per sleep slot, S_GEN and S_DISP
// per core, plus S_POP per dispatch or S_ACK for a lone ack; sleep list compaction runs at one slot per cycle
// the output register lets the next request enter while the last result waits
// synchronous active-low reset clears counters, queue pointers and config
module multicore_fifo_dispatch_with_sleep
  import mfds_pkg::*;
#(
  parameter int READY_DEPTH = mfds_pkg::READY_DEPTH,
  parameter int SLEEP_SLOTS = mfds_pkg::SLEEP_SLOTS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mfds_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mfds_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mfds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  mfds_dp #(.READY_DEPTH(READY_DEPTH), .SLEEP_SLOTS(SLEEP_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== design/mfds_ram.sv =====
module mfds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mfds_dp.sv =====
module mfds_dp #(
  parameter int READY_DEPTH = 64,
  parameter int SLEEP_SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mfds_pkg::ctl_t   ctl,
  output mfds_pkg::sts_t   sts,
  input  mfds_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mfds_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import mfds_pkg::*;

  localparam int RA_W = $clog2(READY_DEPTH);
  localparam int RC_W = $clog2(READY_DEPTH + 1);
  localparam int SA_W = (SLEEP_SLOTS > 1) ? $clog2(SLEEP_SLOTS) : 1;
  localparam int SC_W = $clog2(SLEEP_SLOTS + 1);

  logic [1:0]      policy_r;
  logic [15:0]     quantum_r, period_r;
  in_t             item_r;
  logic [RC_W-1:0] rcount_r, rcount_nxt;
  logic [RA_W-1:0] rhead_r, rhead_nxt;
  logic [SC_W-1:0] scount_r, scount_nxt;
  logic [SA_W-1:0] scan_i_r, scan_i_nxt, keep_r, keep_nxt;
  logic [31:0]     cycle_r, cycle_nxt, old_r, old_nxt;
  logic [15:0]     phase_r, phase_nxt;
  logic [7:0]      next_id_r, next_id_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            rfull, sfull, rq_we, sl_we, sl_re, push, pop, due, later, emit;
  logic [RA_W-1:0] rq_waddr;
  logic [RA_W:0]   pos_sum;
  logic [7:0]      rq_wdata, rq_rdata;
  logic [SA_W-1:0] sl_waddr, sl_raddr;
  logic [39:0]     sl_wdata, sl_rdata;
  logic [31:0]     diff;
  logic [16:0]     phase_inc;

  assign rfull = rcount_r == RC_W'(READY_DEPTH);
  assign sfull = scount_r == SC_W'(SLEEP_SLOTS);
  assign diff  = old_r - sl_rdata[31:0];
  assign due   = !diff[31];
  assign phase_inc = {1'b0, phase_r} + 17'd1;

  assign pos_sum = {1'b0, rhead_r} + (RA_W+1)'(rcount_r);
  assign rq_waddr = (pos_sum >= (RA_W+1)'(READY_DEPTH)) ?
                    RA_W'(pos_sum - (RA_W+1)'(READY_DEPTH)) : pos_sum[RA_W-1:0];

  assign sts.cmd         = item_r.cmd;
  assign sts.sleep_empty = scount_r == '0;
  assign sts.last_slot   = ({1'b0, scan_i_r} + (SA_W+1)'(1)) == (SA_W+1)'(scount_r);
  assign sts.ready_empty = rcount_r == '0;
  assign sts.gen_now     = (period_r != '0) && item_r.batch_on && (phase_r == '0);
  assign sts.can_disp    = (policy_r == POL_FCFS) || (policy_r == POL_RR);
  assign sts.core_free   = item_r.core_free;
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    later = 1'b0;
    for (int k = 0; k < NUM_CORES; k++) begin
      if (k > int'(ctl.core) && item_r.core_free[k]) begin
        later = 1'b1;
      end
    end
  end

  always_comb begin
    push     = 1'b0;
    rq_wdata = item_r.task_id;
    sl_we    = 1'b0;
    sl_waddr = keep_r;
    sl_wdata = sl_rdata;
    sl_re    = 1'b0;
    sl_raddr = '0;
    pop      = ctl.disp;
    rhead_nxt   = rhead_r;
    scount_nxt  = scount_r;
    scan_i_nxt  = scan_i_r;
    keep_nxt    = keep_r;
    cycle_nxt   = cycle_r;
    old_nxt     = old_r;
    phase_nxt   = phase_r;
    next_id_nxt = next_id_r;
    emit        = 1'b0;
    out_nxt     = '0;
    out_nxt.last = 1'b1;

    if (ctl.simple) begin
      emit = 1'b1;
      out_nxt.out_task = item_r.task_id;
      unique case (item_r.cmd)
        CMD_ADD: begin
          push = !rfull;
          out_nxt.kind = rfull ? KIND_REJ : KIND_ACK;
        end
        CMD_REQ: begin
          if (item_r.sleep_ticks != '0) begin
            sl_we    = !sfull;
            sl_waddr = SA_W'(scount_r);
            sl_wdata = {item_r.task_id, cycle_r + 32'(item_r.sleep_ticks)};
            scount_nxt = sfull ? scount_r : scount_r + SC_W'(1);
            out_nxt.kind = sfull ? KIND_REJ : KIND_ACK;
          end else begin
            push = !rfull;
            out_nxt.kind = rfull ? KIND_REJ : KIND_ACK;
          end
        end
        default: begin
          out_nxt.out_task = '0;
        end
      endcase
    end

    if (ctl.scan_start) begin
      old_nxt    = cycle_r;
      cycle_nxt  = cycle_r + 32'd1;
      scan_i_nxt = '0;
      keep_nxt   = '0;
      sl_re      = scount_r != '0;
    end

    if (ctl.scan_step) begin
      if (due && !rfull) begin
        push     = 1'b1;
        rq_wdata = sl_rdata[39:32];
      end else begin
        sl_we    = 1'b1;
        keep_nxt = keep_r + SA_W'(1);
      end
      scan_i_nxt = scan_i_r + SA_W'(1);
      sl_raddr   = scan_i_r + SA_W'(1);
      sl_re      = !sts.last_slot;
      if (sts.last_slot) begin
        scount_nxt = (due && !rfull) ? SC_W'(keep_r) : SC_W'(keep_r) + SC_W'(1);
      end
    end

    if (ctl.gen) begin
      if (sts.gen_now) begin
        emit     = 1'b1;
        push     = !rfull;
        rq_wdata = next_id_r;
        next_id_nxt = next_id_r + 8'd1;
        out_nxt.kind     = rfull ? KIND_REJ : KIND_NEW;
        out_nxt.out_task = next_id_r;
        out_nxt.last     = !(sts.can_disp && (item_r.core_free != '0));
      end
      if (period_r != '0) begin
        phase_nxt = (phase_inc >= {1'b0, period_r}) ? '0 : phase_inc[15:0];
      end else begin
        phase_nxt = '0;
      end
    end

    if (ctl.disp) begin
      emit = 1'b1;
      out_nxt.kind       = KIND_DISP;
      out_nxt.core_index = ctl.core;
      out_nxt.out_task   = rq_rdata;
      out_nxt.budget     = (policy_r == POL_RR) ? quantum_r : '0;
      out_nxt.last       = (rcount_r == RC_W'(1)) || !later;
      rhead_nxt = (rhead_r == RA_W'(READY_DEPTH - 1)) ? '0 : rhead_r + RA_W'(1);
    end

    if (ctl.ack) begin
      emit = 1'b1;
    end

    rq_we = push;
    if (push) begin
      rcount_nxt = rcount_r + RC_W'(1);
    end else if (pop) begin
      rcount_nxt = rcount_r - RC_W'(1);
    end else begin
      rcount_nxt = rcount_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    if (!emit) begin
      out_nxt = out_r;
    end
  end

  mfds_ram #(.WIDTH(8), .DEPTH(READY_DEPTH), .AW(RA_W)) u_ready_ram (
    .clk     (clk),
    .we      (rq_we),
    .wr_addr (rq_waddr),
    .wr_data (rq_wdata),
    .rd_en   (ctl.pop_rd),
    .rd_addr (rhead_r),
    .rd_data (rq_rdata)
  );

  mfds_ram #(.WIDTH(40), .DEPTH(SLEEP_SLOTS), .AW(SA_W)) u_sleep_ram (
    .clk     (clk),
    .we      (sl_we),
    .wr_addr (sl_waddr),
    .wr_data (sl_wdata),
    .rd_en   (sl_re),
    .rd_addr (sl_raddr),
    .rd_data (sl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FCFS;
      quantum_r   <= QUANTUM_RST;
      period_r    <= '0;
      rcount_r    <= '0;
      rhead_r     <= '0;
      scount_r    <= '0;
      cycle_r     <= '0;
      phase_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:  policy_r  <= cfg_data[1:0];
          CFG_QUANTUM: quantum_r <= cfg_data;
          CFG_PERIOD:  period_r  <= cfg_data;
          default: ;
        endcase
      end
      rcount_r    <= rcount_nxt;
      rhead_r     <= rhead_nxt;
      scount_r    <= scount_nxt;
      cycle_r     <= cycle_nxt;
      phase_r     <= phase_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    scan_i_r <= scan_i_nxt;
    keep_r   <= keep_nxt;
    old_r    <= old_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r <= RC_W'(READY_DEPTH)) else $error("ready count overflow");

  a_sleep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scount_r <= SC_W'(SLEEP_SLOTS)) else $error("sleep count overflow");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> sts.out_free) else $error("result overwritten");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.disp |-> rcount_r != '0) else $error("pop from empty queue");

endmodule

// ===== design/mfds_ctrl.sv =====
module mfds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mfds_pkg::sts_t sts,
  output mfds_pkg::ctl_t ctl
);
  import mfds_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SIMPLE = 3'd1;
  localparam logic [2:0] S_SCAN0  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_GEN    = 3'd4;
  localparam logic [2:0] S_DISP   = 3'd5;
  localparam logic [2:0] S_POP    = 3'd6;
  localparam logic [2:0] S_ACK    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] core_r, core_nxt;
  logic       emitted_r, emitted_nxt;
  logic       last_core;

  assign in_stall  = state_r != S_IDLE;
  assign last_core = core_r == 2'(NUM_CORES - 1);

  always_comb begin
    state_nxt   = state_r;
    core_nxt    = core_r;
    emitted_nxt = emitted_r;
    ctl         = '0;
    ctl.core    = core_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_SIMPLE;
        end
      end
      S_SIMPLE: begin
        if (sts.cmd == CMD_TICK) begin
          state_nxt = S_SCAN0;
        end else if (sts.out_free) begin
          ctl.simple = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN0: begin
        ctl.scan_start = 1'b1;
        state_nxt = sts.sleep_empty ? S_GEN : S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.last_slot) begin
          state_nxt = S_GEN;
        end
      end
      S_GEN: begin
        if (!sts.gen_now || sts.out_free) begin
          ctl.gen     = 1'b1;
          emitted_nxt = sts.gen_now;
          core_nxt    = '0;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.core_free[core_r] && !sts.ready_empty && sts.can_disp) begin
          ctl.pop_rd = 1'b1;
          state_nxt  = S_POP;
        end else if (last_core) begin
          state_nxt = emitted_r ? S_IDLE : S_ACK;
        end else begin
          core_nxt = core_r + 2'd1;
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          ctl.disp    = 1'b1;
          emitted_nxt = 1'b1;
          if (last_core) begin
            state_nxt = S_IDLE;
          end else begin
            core_nxt  = core_r + 2'd1;
            state_nxt = S_DISP;
          end
        end
      end
      S_ACK: begin
        if (sts.out_free) begin
          ctl.ack   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      core_r    <= '0;
      emitted_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      core_r    <= core_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.simple, ctl.scan_step, ctl.gen, ctl.disp, ctl.ack}))
    else $error("conflicting datapath commands");

  a_pop_then_disp: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop_rd |=> state_r == S_POP) else $error("pop read not followed");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !in_stall) else $error("load while busy");

endmodule
